/* hdl/crse_pkg.sv */
// ----------------------------------------------------------------------------
// crse_pkg
// Shared constants, types and sizing functions for the Catmull-Rom segment
// evaluator.
// ----------------------------------------------------------------------------
package crse_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int MUL_CHUNK_BITS  = 32;
    localparam int OUT_W           = 18;
    localparam int STEP_W          = 2;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POS   = 2'd1,
        ACT_DERIV = 2'd2
    } crse_action_t;

    typedef struct packed {
        logic              push;
        logic              load;
        logic              start;
        logic              issue;
        logic              accum;
        logic              add;
        logic              round;
        logic              sat;
        logic              emit;
        logic              deriv;
        logic [STEP_W-1:0] step;
    } crse_ctl_t;

    function automatic int sum_width(int coord_bits, int t_frac_bits);
        return coord_bits + 3 * t_frac_bits + 6;
    endfunction

    function automatic int chunk_count(int coord_bits, int t_frac_bits);
        return (sum_width(coord_bits, t_frac_bits) + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
    endfunction

endpackage

/* hdl/crse_in_if.sv */
// ----------------------------------------------------------------------------
// crse_in_if
// Command channel: push a control point or request an evaluation.
// ----------------------------------------------------------------------------
interface crse_in_if
    import crse_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  point_z;
    logic [T_FRAC_BITS:0]          param_t;

    modport source (
        output valid, action, point_x, point_y, point_z, param_t,
        input  ready
    );

    modport sink (
        input  valid, action, point_x, point_y, point_z, param_t,
        output ready
    );
endinterface

/* hdl/crse_out_if.sv */
// ----------------------------------------------------------------------------
// crse_out_if
// Result channel: one position or derivative word per evaluation.
// ----------------------------------------------------------------------------
interface crse_out_if
    import crse_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  out_x;
    logic signed [OUT_W-1:0]  out_y;
    logic signed [OUT_W-1:0]  out_z;

    modport source (
        output valid, out_x, out_y, out_z,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z,
        output ready
    );
endinterface

/* hdl/crse_lane.sv */
// ----------------------------------------------------------------------------
// crse_lane
// One coordinate lane: point window, basis coefficients, chunked Horner
// multiply-accumulate, rounding and saturation.
// ----------------------------------------------------------------------------
module crse_lane
    import crse_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  crse_ctl_t                     ctl,
    input  logic signed [COORD_BITS-1:0]  point_in,
    input  logic [T_FRAC_BITS:0]          t_val,
    output logic signed [OUT_W-1:0]       result
);

    localparam int CO_W   = COORD_BITS + 5;
    localparam int NCH    = chunk_count(COORD_BITS, T_FRAC_BITS);
    localparam int PAD_W  = NCH * MUL_CHUNK_BITS;
    localparam int PROD_W = MUL_CHUNK_BITS + T_FRAC_BITS + 1;

    logic signed [COORD_BITS-1:0] win_reg [4];

    logic signed [CO_W-1:0] p0e, p1e, p2e, p3e;
    logic signed [CO_W-1:0] coef_a, coef_b, coef_c, coef_c3;
    logic signed [CO_W-1:0] a_reg, b_reg, d_reg;

    logic [PAD_W-1:0]        acc_reg;
    logic [PAD_W-1:0]        mcand_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [PAD_W-1:0]        addend;
    logic [PAD_W-1:0]        half;
    logic [PAD_W-1:0]        acc_shl;
    logic signed [PAD_W-1:0] acc_s;
    logic signed [PAD_W-1:0] scaled;
    logic signed [PAD_W-1:0] sat_hi;
    logic signed [PAD_W-1:0] sat_lo;
    logic signed [OUT_W-1:0] result_reg;

    function automatic logic [PAD_W-1:0] widen(logic signed [CO_W-1:0] v);
        return {{(PAD_W-CO_W){v[CO_W-1]}}, v};
    endfunction

    // hold four latest points, newest at the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctl.push)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= point_in;
        end
    end

    assign p0e = {{5{win_reg[0][COORD_BITS-1]}}, win_reg[0]};
    assign p1e = {{5{win_reg[1][COORD_BITS-1]}}, win_reg[1]};
    assign p2e = {{5{win_reg[2][COORD_BITS-1]}}, win_reg[2]};
    assign p3e = {{5{win_reg[3][COORD_BITS-1]}}, win_reg[3]};

    assign coef_a  = p2e - p0e;
    assign coef_b  = (p0e <<< 1) - (p1e <<< 2) - p1e + (p2e <<< 2) - p3e;
    assign coef_c  = (p1e <<< 1) + p1e - (p2e <<< 1) - p2e + p3e - p0e;
    assign coef_c3 = (coef_c <<< 1) + coef_c;

    always_comb
    begin
        case (ctl.step)
            2'd0:    addend = widen(b_reg) << T_FRAC_BITS;
            2'd1:    addend = widen(a_reg) << (2 * T_FRAC_BITS);
            default: addend = widen(d_reg) << (3 * T_FRAC_BITS);
        endcase
    end

    assign half = ctl.deriv ? ({{(PAD_W-1){1'b0}}, 1'b1} << (2 * T_FRAC_BITS))
                            : ({{(PAD_W-1){1'b0}}, 1'b1} << (3 * T_FRAC_BITS));

    assign acc_shl = {acc_reg[PAD_W-MUL_CHUNK_BITS-1:0], {MUL_CHUNK_BITS{1'b0}}};

    assign acc_s  = acc_reg;
    assign scaled = ctl.deriv ? (acc_s >>> (2 * T_FRAC_BITS + 1))
                              : (acc_s >>> (3 * T_FRAC_BITS + 1));
    assign sat_hi = {{(PAD_W-OUT_W){1'b0}}, OUT_MAX};
    assign sat_lo = {{(PAD_W-OUT_W){1'b1}}, OUT_MIN};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg   <= coef_a;
            b_reg   <= ctl.deriv ? (coef_b <<< 1) : coef_b;
            d_reg   <= p1e <<< 1;
            acc_reg <= widen(ctl.deriv ? coef_c3 : coef_c);
        end
        else if (ctl.start)
        begin
            acc_reg <= '0;
        end
        else if (ctl.accum)
        begin
            acc_reg <= acc_shl + {{(PAD_W-PROD_W){1'b0}}, prod_reg};
        end
        else if (ctl.add)
        begin
            acc_reg <= acc_reg + addend;
        end
        else if (ctl.round)
        begin
            acc_reg <= acc_reg + half;
        end

        if (ctl.start)
        begin
            mcand_reg <= acc_reg;
        end
        else if (ctl.issue)
        begin
            mcand_reg <= {mcand_reg[PAD_W-MUL_CHUNK_BITS-1:0], {MUL_CHUNK_BITS{1'b0}}};
        end

        if (ctl.issue)
        begin
            prod_reg <= mcand_reg[PAD_W-1 -: MUL_CHUNK_BITS] * t_val;
        end

        if (ctl.sat)
        begin
            if (scaled > sat_hi)
            begin
                result_reg <= OUT_MAX;
            end
            else if (scaled < sat_lo)
            begin
                result_reg <= OUT_MIN;
            end
            else
            begin
                result_reg <= scaled[OUT_W-1:0];
            end
        end
    end

    assign result = result_reg;

endmodule

/* hdl/crse_ctrl.sv */
// ----------------------------------------------------------------------------
// crse_ctrl
// Sequencer shared by the lanes: accepts commands, steps the Horner
// evaluation and hands finished words to the output register.
// ----------------------------------------------------------------------------
module crse_ctrl
    import crse_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  logic [1:0]            cmd_action,
    input  logic [T_FRAC_BITS:0]  cmd_t,
    input  logic                  res_ready,
    output logic                  cmd_ready,
    output logic                  res_valid,
    output crse_ctl_t             ctl,
    output logic [T_FRAC_BITS:0]  t_val
);

    localparam int NCH   = chunk_count(COORD_BITS, T_FRAC_BITS);
    localparam int CNT_W = $clog2(NCH + 1);

    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START,
        ST_MUL,
        ST_ADD,
        ST_ROUND,
        ST_SAT,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                deriv_reg;
    logic                res_valid_reg;
    logic [T_FRAC_BITS:0] t_reg;

    logic cmd_fire;
    logic last_step;
    logic emit;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign last_step = deriv_reg ? (step_reg == STEP_W'(1)) : (step_reg == STEP_W'(2));
    assign emit      = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            deriv_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        unique case (cmd_action) inside
                            ACT_POS, ACT_DERIV:
                            begin
                                deriv_reg <= (cmd_action == ACT_DERIV);
                                state_reg <= ST_LOAD;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NCH))
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    if (last_step)
                    begin
                        state_reg <= ST_ROUND;
                    end
                    else
                    begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_START;
                    end
                end
                ST_ROUND:
                begin
                    state_reg <= ST_SAT;
                end
                ST_SAT:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (emit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // clamp t to one
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            t_reg <= (cmd_t > T_ONE) ? T_ONE : cmd_t;
        end
    end

    always_comb
    begin
        ctl       = '0;
        ctl.push  = cmd_fire && (cmd_action == ACT_PUSH);
        ctl.load  = (state_reg == ST_LOAD);
        ctl.start = (state_reg == ST_START);
        ctl.issue = (state_reg == ST_MUL) && (cnt_reg != CNT_W'(NCH));
        ctl.accum = (state_reg == ST_MUL) && (cnt_reg != '0);
        ctl.add   = (state_reg == ST_ADD);
        ctl.round = (state_reg == ST_ROUND);
        ctl.sat   = (state_reg == ST_SAT);
        ctl.emit  = emit;
        ctl.deriv = deriv_reg;
        ctl.step  = step_reg;
    end

    assign res_valid = res_valid_reg;
    assign t_val     = t_reg;

endmodule

/* hdl/catmull_rom_segment_eval.sv */
// ----------------------------------------------------------------------------
// catmull_rom_segment_eval
// Uniform Catmull-Rom segment evaluator, three coordinate lanes merged into
// one result word.
//
//   channel | dir | word
//   --------+-----+-------------------------------------------------------
//   cmd     | in  | action, point_x, point_y, point_z, param_t
//   res     | out | out_x, out_y, out_z
//
// With N = ceil((COORD_BITS + 3*T_FRAC_BITS + 6)/32), each lane runs its
// Horner steps for a position or a derivative through one 32-bit chunk
// multiplier, N chunks per step.
// Reset clears the point window to zeros and drops any pending word.
// A stalled result holds in the output register while the next command is
// taken; a new result waits until that register frees.
// ----------------------------------------------------------------------------
module catmull_rom_segment_eval
    import crse_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    crse_in_if.sink     cmd,
    crse_out_if.source  res
);

    crse_ctl_t               ctl;
    logic [T_FRAC_BITS:0]    t_val;
    logic                    res_valid;
    logic signed [COORD_BITS-1:0] lane_pt  [3];
    logic signed [OUT_W-1:0]      lane_res [3];
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg, out_z_reg;

    crse_ctrl #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_action (cmd.action),
        .cmd_t      (cmd.param_t),
        .res_ready  (res.ready),
        .cmd_ready  (cmd.ready),
        .res_valid  (res_valid),
        .ctl        (ctl),
        .t_val      (t_val)
    );

    assign lane_pt[0] = cmd.point_x;
    assign lane_pt[1] = cmd.point_y;
    assign lane_pt[2] = cmd.point_z;

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        crse_lane #(
            .COORD_BITS  (COORD_BITS),
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .point_in (lane_pt[g]),
            .t_val    (t_val),
            .result   (lane_res[g])
        );
    end

    // merge lane results into the output word
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_x_reg <= lane_res[0];
            out_y_reg <= lane_res[1];
            out_z_reg <= lane_res[2];
        end
    end

    assign res.valid = res_valid;
    assign res.out_x = out_x_reg;
    assign res.out_y = out_y_reg;
    assign res.out_z = out_z_reg;

endmodule
